// ===== hdl/rbpa_pkg.sv =====
// Shared types, codes and constants of the reserved buffer pool allocator.
package rbpa_pkg;

    localparam int ID_W        = 8;
    localparam int CNT_W       = 9;
    localparam int ADDR_W      = ID_W;
    localparam int MAP_N       = 2 ** ID_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_INDEX_W = 2;

    localparam logic [CNT_W-1:0] POOL_DEPTH = CNT_W'(MAP_N);
    localparam logic [CNT_W-1:0] ACTIVE_MAX = CNT_W'(256);

    localparam logic [1:0] OP_ALLOC_MAIN   = 2'd0;
    localparam logic [1:0] OP_ALLOC_SECOND = 2'd1;
    localparam logic [1:0] OP_FREE         = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RESERVE = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_MAIN_POOL_SIZE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_POOL_SIZE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RESERVED_STREAMS = 2'd2;

    typedef enum logic [2:0] {
        CMD_ALLOC_MAIN   = 3'd0,
        CMD_ALLOC_SECOND = 3'd1,
        CMD_FREE_MAIN    = 3'd2,
        CMD_FREE_SECOND  = 3'd3,
        CMD_BAD          = 3'd4
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t       kind;
        logic            first;
        logic [ID_W-1:0] id;
        logic            last;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  granted;
        logic [CNT_W-1:0] main_free;
        logic [CNT_W-1:0] active;
    } res_t;

    function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] size);
        eff_size = (size > POOL_DEPTH) ? POOL_DEPTH : size;
    endfunction

endpackage

// ===== hdl/reserved_buffer_pool_allocator.sv =====
// Top level of the reserved buffer pool allocator.
//
// Hands out buffer ids from a main and a secondary pool, each a FIFO free list
// refilled with ids 0 upward on every register write (index 0 main pool size,
// 1 secondary pool size, 2 reserved streams; other indexes are ignored). A
// request word is taken whenever the two-entry command queue has room. The
// engine answers a free, a refusal or a bad request in its exec state, and a
// granted allocation in the exec state and then the pop state, which takes the
// registered read of the free-list memory. Frees run at one word per cycle while
// results drain; grants stall the next word. Results wait in an output register
// and the engine keeps working on the next word while it is taken. A refill
// needs no sweep: a push counter per pool tells which free-list slots hold
// pushed ids, the rest read as their own index, so the block is ready in the
// cycle after a write.
module reserved_buffer_pool_allocator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,  // first_of_stream, buffer_id, zero pad
    input  logic [2:0]                        s_axis_tuser,  // opcode[1:0], from_second_pool
    input  logic                              s_axis_tlast,  // last_of_stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,  // granted_id, main_free_count,
                                                             // active_stream_count, zero pad
    output logic [1:0]                        m_axis_tuser,  // status
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rbpa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rbpa_pkg::CNT_W-1:0]        cfg_data
);

    rbpa_pkg::cmd_t front_cmd, queue_cmd;
    rbpa_pkg::res_t res;
    logic           front_valid, front_ready;
    logic           queue_valid, queue_ready;

    rbpa_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .cmd_valid     (front_valid),
        .cmd_ready     (front_ready),
        .cmd           (front_cmd)
    );

    rbpa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_cmd   (front_cmd),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_cmd   (queue_cmd)
    );

    rbpa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {6'b0, res.active, res.main_free, res.granted};

`ifndef SYNTH
    // an accepted word is in the queue at the next edge
    a_word_queued: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> queue_valid)
        else $error("accepted word missing from command queue");

    // free count never exceeds the pool depth
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> res.main_free <= rbpa_pkg::POOL_DEPTH)
        else $error("main free count beyond pool depth");

    // a grant is reported only with status ok
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.status != rbpa_pkg::ST_OK |-> res.granted == '0)
        else $error("nonzero granted id on a refused item");
`endif

endmodule

// ===== hdl/rbpa_front.sv =====
// Input stage: decode a request word into an engine command.
module rbpa_front (
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,  // first_of_stream, buffer_id, zero pad
    input  logic [2:0]          s_axis_tuser,  // opcode[1:0], from_second_pool
    input  logic                s_axis_tlast,  // last_of_stream
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output rbpa_pkg::cmd_t      cmd
);

    logic [1:0] opcode;
    logic       from_second;

    assign opcode      = s_axis_tuser[1:0];
    assign from_second = s_axis_tuser[2];

    always_comb
    begin
        cmd.first = s_axis_tdata[0];
        cmd.id    = s_axis_tdata[rbpa_pkg::ID_W:1];
        cmd.last  = s_axis_tlast;
        unique case (opcode)
            rbpa_pkg::OP_ALLOC_MAIN:   cmd.kind = rbpa_pkg::CMD_ALLOC_MAIN;
            rbpa_pkg::OP_ALLOC_SECOND: cmd.kind = rbpa_pkg::CMD_ALLOC_SECOND;
            rbpa_pkg::OP_FREE:
            begin
                cmd.kind = from_second ? rbpa_pkg::CMD_FREE_SECOND
                                       : rbpa_pkg::CMD_FREE_MAIN;
            end
            default:                   cmd.kind = rbpa_pkg::CMD_BAD;
        endcase
    end

    assign cmd_valid     = s_axis_tvalid;
    assign s_axis_tready = cmd_ready;

endmodule

// ===== hdl/rbpa_queue.sv =====
// Short command queue between the input stage and the pool engine.
module rbpa_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  rbpa_pkg::cmd_t wr_cmd,
    output logic           rd_valid,
    input  logic           rd_ready,
    output rbpa_pkg::cmd_t rd_cmd
);

    rbpa_pkg::cmd_t                entry_reg [rbpa_pkg::QUEUE_DEPTH];
    logic [rbpa_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [rbpa_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [rbpa_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                          wr_fire, rd_fire;

    assign wr_ready = (count_reg != rbpa_pkg::QCNT_W'(rbpa_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;
    assign rd_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_fire ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_fire ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_fire && !rd_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_fire && !wr_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ===== hdl/rbpa_back.sv =====
// Pool engine: free lists, free maps, stream counter, configuration and result register.
module rbpa_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rbpa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rbpa_pkg::CNT_W-1:0]          cfg_data,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  rbpa_pkg::cmd_t                      cmd,
    output logic                                res_valid,
    input  logic                                res_ready,
    output rbpa_pkg::res_t                      res
);

    localparam int AW = rbpa_pkg::ADDR_W;
    localparam int CW = rbpa_pkg::CNT_W;
    localparam int NM = rbpa_pkg::MAP_N;

    typedef enum logic [1:0] {
        S_EXEC = 2'b01,
        S_POP  = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      main_size_reg, main_size_next;
    logic [CW-1:0]      second_size_reg, second_size_next;
    logic [CW-1:0]      reserved_reg, reserved_next;
    logic [AW-1:0]      main_head_reg, main_head_next;
    logic [CW-1:0]      main_count_reg, main_count_next;
    logic [CW-1:0]      main_push_reg, main_push_next;
    logic [AW-1:0]      second_head_reg, second_head_next;
    logic [CW-1:0]      second_count_reg, second_count_next;
    logic [CW-1:0]      second_push_reg, second_push_next;
    logic [CW-1:0]      active_reg, active_next;
    logic [NM-1:0]      main_map_reg, main_map_next;
    logic [NM-1:0]      second_map_reg, second_map_next;
    logic               pop_second_reg, pop_second_next;
    logic [AW-1:0]      pop_pos_reg, pop_pos_next;
    logic               out_valid_reg, out_valid_next;
    rbpa_pkg::res_t     out_reg, out_next;

    logic [AW-1:0]      main_mem [NM];
    logic [AW-1:0]      second_mem [NM];
    logic [AW-1:0]      main_rd_reg;
    logic [AW-1:0]      second_rd_reg;

    logic               cfg_fire, take, out_free;
    logic [CW-1:0]      eff_main, eff_second, eff_main_new, eff_second_new;
    logic               reserve_hold, main_id_ok, second_id_ok;
    logic [AW-1:0]      main_tail, second_tail;
    logic               main_wr_en, main_rd_en, second_wr_en, second_rd_en;
    logic [AW-1:0]      pop_offset, pop_data;
    logic [CW-1:0]      pop_push;
    logic [AW-1:0]      granted;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || res_ready;
    assign cmd_ready = (state_reg == S_EXEC) && out_free;
    assign take      = cmd_valid && cmd_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    assign eff_main   = rbpa_pkg::eff_size(main_size_reg);
    assign eff_second = rbpa_pkg::eff_size(second_size_reg);

    // main_count < reserved - active, folded into one add and compare
    assign reserve_hold = !cmd.first && (eff_second != '0) &&
        (({1'b0, main_count_reg} + {1'b0, active_reg}) < {1'b0, reserved_reg});

    assign main_tail    = main_head_reg + main_count_reg[AW-1:0];
    assign second_tail  = second_head_reg + second_count_reg[AW-1:0];
    assign main_id_ok   = ({1'b0, cmd.id} < eff_main) && !main_map_reg[cmd.id];
    assign second_id_ok = ({1'b0, cmd.id} < eff_second) && !second_map_reg[cmd.id];

    assign main_rd_en   = take && (cmd.kind == rbpa_pkg::CMD_ALLOC_MAIN) &&
                          !reserve_hold && (main_count_reg != '0);
    assign second_rd_en = take && (cmd.kind == rbpa_pkg::CMD_ALLOC_SECOND) &&
                          (second_count_reg != '0);
    assign main_wr_en   = take && (cmd.kind == rbpa_pkg::CMD_FREE_MAIN) && main_id_ok;
    assign second_wr_en = take && (cmd.kind == rbpa_pkg::CMD_FREE_SECOND) && second_id_ok;

    // A slot holds a pushed id only once the push run since refill has reached it;
    // before that it still holds its own index.
    always_comb
    begin
        if (pop_second_reg)
        begin
            pop_offset = pop_pos_reg - eff_second[AW-1:0];
            pop_push   = second_push_reg;
            pop_data   = second_rd_reg;
        end
        else
        begin
            pop_offset = pop_pos_reg - eff_main[AW-1:0];
            pop_push   = main_push_reg;
            pop_data   = main_rd_reg;
        end
        granted = ({1'b0, pop_offset} < pop_push) ? pop_data : pop_pos_reg;
    end

    always_comb
    begin
        main_size_new_calc();
    end

    function automatic void main_size_new_calc();
    endfunction

    always_comb
    begin
        main_size_next   = main_size_reg;
        second_size_next = second_size_reg;
        reserved_next    = reserved_reg;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                rbpa_pkg::REG_MAIN_POOL_SIZE:   main_size_next   = cfg_data;
                rbpa_pkg::REG_SECOND_POOL_SIZE: second_size_next = cfg_data;
                rbpa_pkg::REG_RESERVED_STREAMS: reserved_next    = cfg_data;
                default: ;
            endcase
        end
    end

    assign eff_main_new   = rbpa_pkg::eff_size(main_size_next);
    assign eff_second_new = rbpa_pkg::eff_size(second_size_next);

    always_comb
    begin
        state_next        = state_reg;
        main_head_next    = main_head_reg;
        main_count_next   = main_count_reg;
        main_push_next    = main_push_reg;
        second_head_next  = second_head_reg;
        second_count_next = second_count_reg;
        second_push_next  = second_push_reg;
        active_next       = active_reg;
        main_map_next     = main_map_reg;
        second_map_next   = second_map_reg;
        pop_second_next   = pop_second_reg;
        pop_pos_next      = pop_pos_reg;
        out_valid_next    = out_valid_reg && !res_ready;
        out_next          = out_reg;

        if (cfg_fire && (cfg_index == rbpa_pkg::REG_MAIN_POOL_SIZE ||
                         cfg_index == rbpa_pkg::REG_SECOND_POOL_SIZE ||
                         cfg_index == rbpa_pkg::REG_RESERVED_STREAMS))
        begin
            // refill both pools
            state_next        = S_EXEC;
            main_head_next    = '0;
            main_count_next   = eff_main_new;
            main_push_next    = '0;
            second_head_next  = '0;
            second_count_next = eff_second_new;
            second_push_next  = '0;
            active_next       = '0;
            for (int i = 0; i < NM; i++)
            begin
                main_map_next[i]   = (CW'(i) < eff_main_new);
                second_map_next[i] = (CW'(i) < eff_second_new);
            end
        end
        else if (state_reg == S_POP)
        begin
            if (pop_second_reg)
            begin
                second_map_next[granted] = 1'b0;
            end
            else
            begin
                main_map_next[granted] = 1'b0;
            end
            out_valid_next    = 1'b1;
            out_next.status    = rbpa_pkg::ST_OK;
            out_next.granted   = granted;
            out_next.main_free = main_count_reg;
            out_next.active    = active_reg;
            state_next         = S_EXEC;
        end
        else if (take)
        begin
            out_next.status    = rbpa_pkg::ST_BAD;
            out_next.granted   = '0;
            out_next.main_free = main_count_reg;
            out_next.active    = active_reg;
            out_valid_next     = 1'b1;
            unique case (cmd.kind)
                rbpa_pkg::CMD_ALLOC_MAIN:
                begin
                    priority if (reserve_hold)
                    begin
                        out_next.status = rbpa_pkg::ST_RESERVE;
                    end
                    else if (main_count_reg == '0)
                    begin
                        out_next.status = rbpa_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        // result goes out after the free list read
                        out_valid_next  = 1'b0;
                        pop_second_next = 1'b0;
                        pop_pos_next    = main_head_reg;
                        main_head_next  = main_head_reg + 1'b1;
                        main_count_next = main_count_reg - 1'b1;
                        if (cmd.first && (active_reg < rbpa_pkg::ACTIVE_MAX))
                        begin
                            active_next = active_reg + 1'b1;
                        end
                        state_next = S_POP;
                    end
                end
                rbpa_pkg::CMD_ALLOC_SECOND:
                begin
                    if (second_count_reg == '0)
                    begin
                        out_next.status = rbpa_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        out_valid_next    = 1'b0;
                        pop_second_next   = 1'b1;
                        pop_pos_next      = second_head_reg;
                        second_head_next  = second_head_reg + 1'b1;
                        second_count_next = second_count_reg - 1'b1;
                        state_next        = S_POP;
                    end
                end
                rbpa_pkg::CMD_FREE_MAIN:
                begin
                    if (main_id_ok)
                    begin
                        main_count_next       = main_count_reg + 1'b1;
                        main_push_next        = (main_push_reg == rbpa_pkg::POOL_DEPTH) ?
                                                main_push_reg : main_push_reg + 1'b1;
                        main_map_next[cmd.id] = 1'b1;
                        if (cmd.last && (active_reg != '0))
                        begin
                            active_next = active_reg - 1'b1;
                        end
                        out_next.status    = rbpa_pkg::ST_OK;
                        out_next.main_free = main_count_next;
                        out_next.active    = active_next;
                    end
                end
                rbpa_pkg::CMD_FREE_SECOND:
                begin
                    if (second_id_ok)
                    begin
                        second_count_next       = second_count_reg + 1'b1;
                        second_push_next        = (second_push_reg == rbpa_pkg::POOL_DEPTH) ?
                                                  second_push_reg : second_push_reg + 1'b1;
                        second_map_next[cmd.id] = 1'b1;
                        out_next.status         = rbpa_pkg::ST_OK;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_EXEC;
            main_size_reg    <= rbpa_pkg::POOL_DEPTH;
            second_size_reg  <= '0;
            reserved_reg     <= '0;
            main_head_reg    <= '0;
            main_count_reg   <= rbpa_pkg::POOL_DEPTH;
            main_push_reg    <= '0;
            second_head_reg  <= '0;
            second_count_reg <= '0;
            second_push_reg  <= '0;
            active_reg       <= '0;
            main_map_reg     <= '1;
            second_map_reg   <= '0;
            pop_second_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            main_size_reg    <= main_size_next;
            second_size_reg  <= second_size_next;
            reserved_reg     <= reserved_next;
            main_head_reg    <= main_head_next;
            main_count_reg   <= main_count_next;
            main_push_reg    <= main_push_next;
            second_head_reg  <= second_head_next;
            second_count_reg <= second_count_next;
            second_push_reg  <= second_push_next;
            active_reg       <= active_next;
            main_map_reg     <= main_map_next;
            second_map_reg   <= second_map_next;
            pop_second_reg   <= pop_second_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_pos_reg <= pop_pos_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (main_wr_en)
        begin
            main_mem[main_tail] <= cmd.id;
        end
        if (main_rd_en)
        begin
            main_rd_reg <= main_mem[main_head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (second_wr_en)
        begin
            second_mem[second_tail] <= cmd.id;
        end
        if (second_rd_en)
        begin
            second_rd_reg <= second_mem[second_head_reg];
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench of the buffer pool allocator: predicts each result, drives random traffic, checks words.
module tb;
    import rbpa_pkg::*;

    localparam logic [1:0]             OP_UNUSED      = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED     = 2'd3;
    localparam int                     LONG_HOLD      = 200;
    localparam int                     WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [1:0] opcode;
        logic       first;
        logic [7:0] id;
        logic       from_spare;
        logic       last;
    } pool_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] granted;
        logic [8:0] main_free;
        logic [8:0] active;
    } alloc_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [15:0]            s_axis_tdata = '0;
    logic [2:0]             s_axis_tuser = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [31:0]            m_axis_tdata;
    logic [1:0]             m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]       cfg_data = '0;

    // predicted allocator state
    logic [7:0] main_ring [256];
    logic [7:0] spare_ring [256];
    logic       main_parked [256];
    logic       spare_parked [256];
    logic [7:0] main_head;
    logic [7:0] spare_head;
    logic [8:0] main_left;
    logic [8:0] spare_left;
    logic [8:0] open_streams;
    logic [8:0] main_size_reg;
    logic [8:0] spare_size_reg;
    logic [8:0] reserve_reg;

    alloc_result_t pending_results[$];

    // buffers the traffic generator holds, tagged by stream
    logic [7:0] held_id[$];
    int         held_tag[$];
    int         live_streams[$];
    logic [7:0] spare_held[$];
    int         next_tag = 0;

    int   errors = 0;
    int   quiet_cycles = 0;
    logic idle_on = 1'b1;
    logic hold_output = 1'b0;

    reserved_buffer_pool_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [8:0] usable(input logic [8:0] size);
        return (size > 9'd256) ? 9'd256 : size;
    endfunction

    function automatic pool_req_t make_req(input logic [1:0] op, input logic first,
                                           input logic [7:0] id, input logic from_spare,
                                           input logic last);
        pool_req_t r;
        r.opcode     = op;
        r.first      = first;
        r.id         = id;
        r.from_spare = from_spare;
        r.last       = last;
        return r;
    endfunction

    task automatic refill_pools();
        int i;
        for (i = 0; i < 256; i++)
        begin
            main_ring[i]    = 8'(i);
            spare_ring[i]   = 8'(i);
            main_parked[i]  = (i < usable(main_size_reg));
            spare_parked[i] = (i < usable(spare_size_reg));
        end
        main_head    = '0;
        spare_head   = '0;
        main_left    = usable(main_size_reg);
        spare_left   = usable(spare_size_reg);
        open_streams = '0;
        held_id.delete();
        held_tag.delete();
        live_streams.delete();
        spare_held.delete();
    endtask

    task automatic predict_grant(input pool_req_t r, output alloc_result_t y);
        logic [8:0] reserve;
        logic [7:0] slot;
        y.status  = ST_BAD;
        y.granted = '0;
        case (r.opcode)
            OP_ALLOC_MAIN:
            begin
                reserve = (open_streams < reserve_reg) ? reserve_reg - open_streams : 9'd0;
                // reserve check wins over an empty pool
                if (!r.first && usable(spare_size_reg) != 0 && main_left < reserve)
                    y.status = ST_RESERVE;
                else if (main_left == 0)
                    y.status = ST_EMPTY;
                else
                begin
                    if (r.first && open_streams < ACTIVE_MAX)
                        open_streams = open_streams + 9'd1;
                    y.granted = main_ring[main_head];
                    main_head = main_head + 8'd1;
                    main_left = main_left - 9'd1;
                    main_parked[y.granted] = 1'b0;
                    y.status = ST_OK;
                end
            end
            OP_ALLOC_SECOND:
            begin
                if (spare_left == 0)
                    y.status = ST_EMPTY;
                else
                begin
                    y.granted  = spare_ring[spare_head];
                    spare_head = spare_head + 8'd1;
                    spare_left = spare_left - 9'd1;
                    spare_parked[y.granted] = 1'b0;
                    y.status = ST_OK;
                end
            end
            OP_FREE:
            begin
                if (r.from_spare)
                begin
                    if (r.id < usable(spare_size_reg) && !spare_parked[r.id])
                    begin
                        slot = spare_head + spare_left[7:0];
                        spare_ring[slot] = r.id;
                        spare_left = spare_left + 9'd1;
                        spare_parked[r.id] = 1'b1;
                        y.status = ST_OK;
                    end
                end
                else if (r.id < usable(main_size_reg) && !main_parked[r.id])
                begin
                    slot = main_head + main_left[7:0];
                    main_ring[slot] = r.id;
                    main_left = main_left + 9'd1;
                    main_parked[r.id] = 1'b1;
                    if (r.last && open_streams > 0)
                        open_streams = open_streams - 9'd1;
                    y.status = ST_OK;
                end
            end
            default: ;
        endcase
        y.main_free = main_left;
        y.active    = open_streams;
    endtask

    // Leaves tvalid high so the next word follows without a bubble.
    task automatic send_req(input pool_req_t r, input int tag);
        alloc_result_t y;
        int k;
        int n;
        int t;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, r.id, r.first};
        s_axis_tuser  <= {r.from_spare, r.opcode};
        s_axis_tlast  <= r.last;
        do @(posedge clk); while (!s_axis_tready);
        predict_grant(r, y);
        pending_results.push_back(y);
        if (y.status != ST_OK)
            return;
        if (r.opcode == OP_ALLOC_MAIN)
        begin
            if (tag < 0)
            begin
                tag = next_tag++;
                live_streams.push_back(tag);
            end
            held_id.push_back(y.granted);
            held_tag.push_back(tag);
        end
        else if (r.opcode == OP_ALLOC_SECOND)
            spare_held.push_back(y.granted);
        else if (r.from_spare)
        begin
            for (k = 0; k < spare_held.size(); k++)
                if (spare_held[k] == r.id)
                begin
                    spare_held.delete(k);
                    break;
                end
        end
        else
        begin
            for (k = 0; k < held_id.size(); k++)
                if (held_id[k] == r.id)
                    break;
            if (k < held_id.size())
            begin
                t = held_tag[k];
                held_id.delete(k);
                held_tag.delete(k);
                n = 0;
                foreach (held_tag[j])
                    if (held_tag[j] == t)
                        n++;
                // drop a stream once it holds nothing
                if (n == 0)
                    for (k = 0; k < live_streams.size(); k++)
                        if (live_streams[k] == t)
                        begin
                            live_streams.delete(k);
                            break;
                        end
            end
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [8:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            REG_MAIN_POOL_SIZE:   main_size_reg  = value;
            REG_SECOND_POOL_SIZE: spare_size_reg = value;
            REG_RESERVED_STREAMS: reserve_reg    = value;
            default: return;
        endcase
        refill_pools();
    endtask

    task automatic program_pools(input logic [8:0] main_size, input logic [8:0] spare_size,
                                 input logic [8:0] reserve);
        write_reg(REG_MAIN_POOL_SIZE, main_size);
        write_reg(REG_SECOND_POOL_SIZE, spare_size);
        write_reg(REG_RESERVED_STREAMS, reserve);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_step();
        pool_req_t r;
        int roll;
        int k;
        int n;
        int t;
        r = '0;
        roll = $urandom_range(0, 99);
        // lean on frees when the main pool runs dry
        if (main_left < 2 && held_id.size() > 0 && roll < 60)
            roll = 90;
        if (roll < 12)
        begin
            r.opcode     = 2'($urandom_range(0, 3));
            r.first      = 1'($urandom);
            r.id         = 8'($urandom);
            r.from_spare = 1'($urandom);
            r.last       = 1'($urandom);
            send_req(r, -1);
        end
        else if (roll < 55)
        begin
            r.opcode = OP_ALLOC_MAIN;
            t = -1;
            if (roll < 32 || live_streams.size() == 0)
                r.first = 1'b1;
            else
                t = live_streams[$urandom_range(0, live_streams.size() - 1)];
            send_req(r, t);
        end
        else if (roll < 65)
        begin
            r.opcode = OP_ALLOC_SECOND;
            send_req(r, -1);
        end
        else if (roll < 75 && spare_held.size() > 0)
        begin
            r.opcode     = OP_FREE;
            r.from_spare = 1'b1;
            r.id         = spare_held[$urandom_range(0, spare_held.size() - 1)];
            r.last       = 1'($urandom);
            send_req(r, -1);
        end
        else if (held_id.size() > 0)
        begin
            k = $urandom_range(0, held_id.size() - 1);
            t = held_tag[k];
            n = 0;
            foreach (held_tag[j])
                if (held_tag[j] == t)
                    n++;
            r.opcode = OP_FREE;
            r.id     = held_id[k];
            r.last   = (n == 1);
            send_req(r, -1);
        end
        else
        begin
            r.opcode = OP_ALLOC_MAIN;
            r.first  = 1'b1;
            send_req(r, -1);
        end
    endtask

    task automatic test_directed();
        // reset settings: full main pool, no secondary pool
        send_req(make_req(OP_ALLOC_MAIN, 1'b1, 8'd0, 1'b0, 1'b0), -1);
        send_req(make_req(OP_ALLOC_MAIN, 1'b0, 8'd0, 1'b0, 1'b0), 0);
        send_req(make_req(OP_ALLOC_SECOND, 1'b1, 8'hFF, 1'b1, 1'b1), -1);
        send_req(make_req(OP_FREE, 1'b0, 8'd1, 1'b0, 1'b0), -1);
        send_req(make_req(OP_FREE, 1'b0, 8'd1, 1'b0, 1'b1), -1);
        send_req(make_req(OP_FREE, 1'b0, 8'd200, 1'b1, 1'b0), -1);
        send_req(make_req(OP_UNUSED, 1'b1, 8'hFF, 1'b1, 1'b1), -1);
        send_req(make_req(OP_FREE, 1'b1, 8'd0, 1'b0, 1'b1), -1);
        send_req(make_req(OP_FREE, 1'b0, 8'd255, 1'b0, 1'b1), -1);
        // stream end with no active stream keeps the count at zero
        send_req(make_req(OP_ALLOC_MAIN, 1'b0, 8'd0, 1'b0, 1'b0), -1);
        send_req(make_req(OP_FREE, 1'b0, 8'd2, 1'b0, 1'b1), -1);
        drain_results();

        program_pools(9'd2, 9'd1, 9'd3);
        send_req(make_req(OP_ALLOC_MAIN, 1'b0, 8'd0, 1'b0, 1'b0), -1);
        send_req(make_req(OP_ALLOC_MAIN, 1'b1, 8'd0, 1'b0, 1'b0), -1);
        send_req(make_req(OP_ALLOC_MAIN, 1'b0, 8'd0, 1'b0, 1'b0), -1);
        send_req(make_req(OP_ALLOC_MAIN, 1'b1, 8'd0, 1'b0, 1'b0), -1);
        send_req(make_req(OP_ALLOC_MAIN, 1'b1, 8'd0, 1'b0, 1'b0), -1);
        send_req(make_req(OP_ALLOC_MAIN, 1'b0, 8'd0, 1'b0, 1'b0), -1);
        send_req(make_req(OP_ALLOC_SECOND, 1'b0, 8'd0, 1'b0, 1'b0), -1);
        send_req(make_req(OP_ALLOC_SECOND, 1'b0, 8'd0, 1'b0, 1'b0), -1);
        send_req(make_req(OP_FREE, 1'b0, 8'd0, 1'b1, 1'b1), -1);
        send_req(make_req(OP_FREE, 1'b0, 8'd1, 1'b1, 1'b0), -1);
        send_req(make_req(OP_FREE, 1'b0, 8'd2, 1'b0, 1'b0), -1);
        drain_results();

        // unused register index must leave the pools alone
        write_reg(REG_UNUSED, 9'h1FF);
        cfg_valid <= 1'b0;
        send_req(make_req(OP_ALLOC_MAIN, 1'b0, 8'd0, 1'b0, 1'b0), -1);
        drain_results();

        program_pools(9'd0, 9'd1, 9'd3);
        send_req(make_req(OP_ALLOC_MAIN, 1'b1, 8'd0, 1'b0, 1'b0), -1);
        send_req(make_req(OP_ALLOC_MAIN, 1'b0, 8'd0, 1'b0, 1'b0), -1);
        send_req(make_req(OP_FREE, 1'b0, 8'd0, 1'b0, 1'b1), -1);
        drain_results();
    endtask

    task automatic test_stream_saturation();
        program_pools(9'd256, 9'd0, 9'd0);
        repeat (256)
            send_req(make_req(OP_ALLOC_MAIN, 1'b1, 8'd0, 1'b0, 1'b0), -1);
        send_req(make_req(OP_FREE, 1'b0, 8'd0, 1'b0, 1'b0), -1);
        send_req(make_req(OP_ALLOC_MAIN, 1'b1, 8'd0, 1'b0, 1'b0), -1);
        send_req(make_req(OP_FREE, 1'b0, 8'd5, 1'b0, 1'b1), -1);
        drain_results();
    endtask

    task automatic test_random_mix(input logic [8:0] main_size, input logic [8:0] spare_size,
                                   input logic [8:0] reserve, input int count);
        program_pools(main_size, spare_size, reserve);
        repeat (count)
            random_step();
        drain_results();
    endtask

    task automatic test_backpressure();
        program_pools(9'd12, 9'd8, 9'd4);
        idle_on = 1'b0;
        hold_output = 1'b1;
        repeat (40)
            random_step();
        drain_results();
        idle_on = 1'b1;
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        test_random_mix(9'd10, 9'd5, 9'd4, 50);
    endtask

    initial
    begin
        main_size_reg  = 9'd256;
        spare_size_reg = 9'd0;
        reserve_reg    = 9'd0;
        refill_pools();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_stream_saturation();
        test_random_mix(9'd8, 9'd4, 9'd3, 40);
        test_random_mix(9'd256, 9'd256, 9'd256, 40);
        test_random_mix(9'd3, 9'd0, 9'd2, 40);
        test_random_mix(9'd16, 9'd16, 9'd6, 40);
        test_random_mix(9'd1, 9'd1, 9'd0, 40);
        test_random_mix(9'd6, 9'd200, 9'd9, 40);
        test_backpressure();
        test_steady_stream();

        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_output)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_output = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        alloc_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected word, status %0d data %h",
                         $time, m_axis_tuser, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[7:0] !== want.granted)
                begin
                    $display("%0t: granted_id expected %0d actual %0d",
                             $time, want.granted, m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tdata[16:8] !== want.main_free)
                begin
                    $display("%0t: main_free_count expected %0d actual %0d",
                             $time, want.main_free, m_axis_tdata[16:8]);
                    errors++;
                end
                if (m_axis_tdata[25:17] !== want.active)
                begin
                    $display("%0t: active_stream_count expected %0d actual %0d",
                             $time, want.active, m_axis_tdata[25:17]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

// ===== files.f =====
hdl/rbpa_pkg.sv
hdl/rbpa_front.sv
hdl/rbpa_queue.sv
hdl/rbpa_back.sv
hdl/reserved_buffer_pool_allocator.sv
test/tb.sv
